[rtl/pdps_pkg.sv]
// shared types and constants of the polyline simplifier
// no dependencies; used by pdps_datapath, pdps_ctrl, the top and the testbench
`default_nettype none

package pdps_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TOL_W           = 16;
  localparam int DIM_W           = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 4;

  localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_TOL = 2'd0;
  localparam logic [1:0] CFG_HQ  = 2'd1;
  localparam logic [1:0] CFG_DIM = 2'd2;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_TAKE,
    OP_SQREF,
    OP_STORE,
    OP_INIT,
    OP_POP,
    OP_SEG,
    OP_RDE,
    OP_GETE,
    OP_SV,
    OP_SQSV,
    OP_SSQ,
    OP_RDP,
    OP_PV,
    OP_MDOT,
    OP_DOT,
    OP_PP,
    OP_QPP,
    OP_PVE,
    OP_MPP2,
    OP_QSUM,
    OP_MUL1,
    OP_NUM1,
    OP_MUL2,
    OP_NUM2,
    OP_DIV,
    OP_QDIV,
    OP_MULX,
    OP_XSAVE,
    OP_MULY,
    OP_BEST,
    OP_NEXTP,
    OP_KEEP,
    OP_PUSH2,
    OP_EMINIT,
    OP_RDI,
    OP_OUT,
    OP_NEXTI,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic sp_zero;
    logic seg_skip;
    logic dot_le0;
    logic ssq_le_dot;
    logic have;
    logic q_gt;
    logic q_eq;
    logic x_gt;
    logic p_end;
    logic keep_best;
    logic i_end;
    logic keep_i;
    logic out_busy;
    logic mul_busy;
    logic div_busy;
  } stat_t;

endpackage

`default_nettype wire

[rtl/pdps_mul.sv]
// shift-add multiplier, one multiplier bit per cycle
// depends on nothing; used by pdps_datapath
`default_nettype none

module pdps_mul #(
  parameter int W = 34
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                busy_o,
  output logic [2*W-1:0]      prod_o
);

  localparam int CNTW = $clog2(W);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [W-1:0]    hi_q, lo_q, mc_q;
  logic [W:0]      sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      mc_q <= a_i;
    end else if (busy_q) begin
      hi_q <= sum[W:1];
      lo_q <= {sum[0], lo_q[W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

[rtl/pdps_div.sv]
// restoring divider, one quotient bit per cycle
// depends on nothing; used by pdps_datapath
`default_nettype none

module pdps_div #(
  parameter int W = 34
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [2*W-1:0] num_i,
  input  wire logic [W-1:0]   den_i,
  output logic                busy_o,
  output logic [W-1:0]        quo_o,
  output logic [W-1:0]        rem_o
);

  localparam int CNTW = $clog2(2 * W);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [2*W-1:0]  n_q;
  logic [W-1:0]    d_q, rem_q, quo_q;
  logic [W:0]      rs, diff;
  logic            ge;

  assign rs   = {rem_q, n_q[2*W-1]};
  assign ge   = rs >= {1'b0, d_q};
  assign diff = rs - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(2 * W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[2*W-2:0], 1'b0};
      rem_q <= ge ? diff[W-1:0] : rs[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[rtl/pdps_datapath.sv]
// point store, segment stack, keep flags and distance arithmetic
// depends on pdps_pkg, pdps_mul and pdps_div; driven by pdps_ctrl
`default_nettype none

module pdps_datapath #(
  parameter int MAX_POINTS  = pdps_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pdps_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pdps_pkg::cmd_t                cmd_i,
  output pdps_pkg::stat_t                    stat_o,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_z_i,
  input  wire logic                          in_last_i,
  input  wire logic [pdps_pkg::TOL_W-1:0]    tol_i,
  input  wire logic                          hq_i,
  input  wire logic [pdps_pkg::DIM_W-1:0]    dims_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic signed [COORD_WIDTH-1:0]      out_z_o,
  output logic                               out_last_o,
  output logic                               out_ovf_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SQW  = 2 * CW + 2;
  localparam int SW   = PW + 2;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = SQW + 32;

  pdps_pkg::op_e op;
  assign op = cmd_i.op;

  logic nd3;
  assign nd3 = dims_i == pdps_pkg::DIM_3D;

  function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b,
                                               input logic en);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return en ? d : '0;
  endfunction

  // memories
  logic [3*CW-1:0] pmem [MAX_POINTS];
  logic [3*CW-1:0] rd_q;
  logic [2*IW-1:0] smem [MAX_POINTS];
  logic [2*IW-1:0] srd_q;

  logic signed [CW-1:0] pt_q [3];
  logic signed [CW-1:0] ref_q [3];
  logic signed [CW-1:0] s_pt_q [3];
  logic signed [CW-1:0] e_pt_q [3];
  logic signed [CW-1:0] rdc [3];
  logic signed [DW-1:0] sv_q [3];
  logic signed [DW-1:0] pv_q [3];
  logic signed [DW-1:0] ma [3];
  logic signed [DW-1:0] mb [3];
  logic signed [PW-1:0] prod_q [3];
  logic signed [SW-1:0] psum;
  logic                 last_q;
  logic [31:0]          tol2_q;

  logic [NW-1:0]        cnt_q, sp_q, i_q;
  logic                 ovf_q;
  logic [MAX_POINTS-1:0] keep_q;
  logic [IW-1:0]        s_q, e_q, p_q, bp_q;
  logic                 have_q;
  logic [SQW-1:0]       ssq_q, pp_q;
  logic signed [SW-1:0] dot_q;
  logic [SQW-1:0]       cq_q, cr_q, cd_q, bq_q, br_q, bd_q;
  logic [2*SQW-1:0]     num_q, x_q;
  logic                 ovalid_q;

  // serial units
  logic             mul_start, mul_busy, div_busy;
  logic [SQW-1:0]   mul_a, mul_b, quo, rem;
  logic [2*SQW-1:0] mprod;

  always_comb begin
    mul_start = 1'b1;
    mul_a     = pp_q;
    mul_b     = ssq_q;
    case (op)
      pdps_pkg::OP_MUL1: begin
        mul_a = pp_q;
        mul_b = ssq_q;
      end
      pdps_pkg::OP_MUL2: begin
        mul_a = dot_q[SQW-1:0];
        mul_b = dot_q[SQW-1:0];
      end
      pdps_pkg::OP_MULX: begin
        mul_a = cr_q;
        mul_b = bd_q;
      end
      pdps_pkg::OP_MULY: begin
        mul_a = br_q;
        mul_b = cd_q;
      end
      default: mul_start = 1'b0;
    endcase
  end

  pdps_mul #(.W(SQW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mprod)
  );

  pdps_div #(.W(SQW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op == pdps_pkg::OP_DIV),
    .num_i   (num_q),
    .den_i   (ssq_q),
    .busy_o  (div_busy),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  // three coordinate multipliers, one per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rdc[k] = rd_q[k*CW +: CW];
      case (op)
        pdps_pkg::OP_SQREF: begin
          ma[k] = dif(pt_q[k], ref_q[k], (k < 2) || nd3);
          mb[k] = ma[k];
        end
        pdps_pkg::OP_SQSV: begin
          ma[k] = sv_q[k];
          mb[k] = sv_q[k];
        end
        pdps_pkg::OP_MDOT: begin
          ma[k] = pv_q[k];
          mb[k] = sv_q[k];
        end
        default: begin
          ma[k] = pv_q[k];
          mb[k] = pv_q[k];
        end
      endcase
    end
    psum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);
  end

  always_ff @(posedge clk_i) begin
    tol2_q <= 32'(tol_i) * 32'(tol_i);
    if (op == pdps_pkg::OP_SQREF || op == pdps_pkg::OP_SQSV || op == pdps_pkg::OP_MDOT ||
        op == pdps_pkg::OP_DOT || op == pdps_pkg::OP_MPP2) begin
      for (int k = 0; k < 3; k++) prod_q[k] <= ma[k] * mb[k];
    end
  end

  // store decision of the radial prefilter
  logic do_store, do_write;
  assign do_store = hq_i || (cnt_q == '0) || last_q ||
                    (CMPW'(psum[SQW-1:0]) > CMPW'(tol2_q));
  assign do_write = (op == pdps_pkg::OP_STORE) && do_store && (cnt_q < NW'(MAX_POINTS));

  // point memory
  logic [IW-1:0] raddr;
  logic          ren;
  always_comb begin
    ren   = 1'b1;
    raddr = p_q;
    case (op)
      pdps_pkg::OP_SEG: raddr = srd_q[2*IW-1:IW];
      pdps_pkg::OP_RDE: raddr = e_q;
      pdps_pkg::OP_RDP: raddr = p_q;
      pdps_pkg::OP_RDI: raddr = i_q[IW-1:0];
      default:          ren   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_write) pmem[cnt_q[IW-1:0]] <= {pt_q[2], pt_q[1], pt_q[0]};
    if (ren) rd_q <= pmem[raddr];
  end

  // segment stack memory
  logic          swe;
  logic [IW-1:0] swa;
  logic [2*IW-1:0] swd;
  logic          sp_room;
  assign sp_room = sp_q < NW'(MAX_POINTS);

  always_comb begin
    swe = 1'b0;
    swa = sp_q[IW-1:0];
    swd = {s_q, bp_q};
    case (op)
      pdps_pkg::OP_INIT: begin
        swe = 1'b1;
        swa = '0;
        swd = {IW'(0), IW'(cnt_q - 1'b1)};
      end
      pdps_pkg::OP_KEEP: begin
        swe = sp_room;
        swd = {bp_q, e_q};
      end
      pdps_pkg::OP_PUSH2: swe = sp_room;
      default: swe = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (swe) smem[swa] <= swd;
    if (op == pdps_pkg::OP_POP) srd_q <= smem[IW'(sp_q - 1'b1)];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      keep_q   <= '0;
      sp_q     <= '0;
      i_q      <= '0;
      have_q   <= 1'b0;
      ovalid_q <= 1'b0;
      last_q   <= 1'b0;
      for (int k = 0; k < 3; k++) ref_q[k] <= '0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (op)
        pdps_pkg::OP_TAKE: last_q <= in_last_i;
        pdps_pkg::OP_STORE: begin
          if (do_write) begin
            cnt_q <= cnt_q + 1'b1;
            for (int k = 0; k < 3; k++) ref_q[k] <= pt_q[k];
          end else if (do_store) begin
            ovf_q <= 1'b1;
          end
        end
        pdps_pkg::OP_INIT: begin
          keep_q[0]                     <= 1'b1;
          keep_q[IW'(cnt_q - 1'b1)]     <= 1'b1;
          sp_q                          <= NW'(1);
        end
        pdps_pkg::OP_POP:   sp_q <= sp_q - 1'b1;
        pdps_pkg::OP_GETE:  have_q <= 1'b0;
        pdps_pkg::OP_BEST:  have_q <= 1'b1;
        pdps_pkg::OP_KEEP: begin
          keep_q[bp_q] <= 1'b1;
          if (sp_room) sp_q <= sp_q + 1'b1;
        end
        pdps_pkg::OP_PUSH2: if (sp_room) sp_q <= sp_q + 1'b1;
        pdps_pkg::OP_EMINIT: i_q <= '0;
        pdps_pkg::OP_NEXTI:  i_q <= i_q + 1'b1;
        pdps_pkg::OP_OUT:    ovalid_q <= 1'b1;
        pdps_pkg::OP_CLEAR: begin
          keep_q <= '0;
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op)
      pdps_pkg::OP_TAKE: begin
        pt_q[0] <= in_x_i;
        pt_q[1] <= in_y_i;
        pt_q[2] <= in_z_i;
      end
      pdps_pkg::OP_SEG: begin
        s_q <= srd_q[2*IW-1:IW];
        e_q <= srd_q[IW-1:0];
      end
      pdps_pkg::OP_RDE:  for (int k = 0; k < 3; k++) s_pt_q[k] <= rdc[k];
      pdps_pkg::OP_GETE: begin
        for (int k = 0; k < 3; k++) e_pt_q[k] <= rdc[k];
        p_q <= s_q + 1'b1;
      end
      pdps_pkg::OP_SV:
        for (int k = 0; k < 3; k++) sv_q[k] <= dif(e_pt_q[k], s_pt_q[k], (k < 2) || nd3);
      pdps_pkg::OP_SSQ: ssq_q <= psum[SQW-1:0];
      pdps_pkg::OP_PV:
        for (int k = 0; k < 3; k++) pv_q[k] <= dif(rdc[k], s_pt_q[k], (k < 2) || nd3);
      pdps_pkg::OP_DOT: dot_q <= psum;
      pdps_pkg::OP_PP:  pp_q <= psum[SQW-1:0];
      pdps_pkg::OP_QPP: begin
        cq_q <= pp_q;
        cr_q <= '0;
        cd_q <= SQW'(1);
      end
      pdps_pkg::OP_PVE:
        for (int k = 0; k < 3; k++) pv_q[k] <= dif(rdc[k], e_pt_q[k], (k < 2) || nd3);
      pdps_pkg::OP_QSUM: begin
        cq_q <= psum[SQW-1:0];
        cr_q <= '0;
        cd_q <= SQW'(1);
      end
      pdps_pkg::OP_NUM1: num_q <= mprod;
      pdps_pkg::OP_NUM2: num_q <= num_q - mprod;
      pdps_pkg::OP_QDIV: begin
        cq_q <= quo;
        cr_q <= rem;
        cd_q <= ssq_q;
      end
      pdps_pkg::OP_XSAVE: x_q <= mprod;
      pdps_pkg::OP_BEST: begin
        bq_q <= cq_q;
        br_q <= cr_q;
        bd_q <= cd_q;
        bp_q <= p_q;
      end
      pdps_pkg::OP_NEXTP: p_q <= p_q + 1'b1;
      pdps_pkg::OP_OUT: begin
        out_x_o    <= rdc[0];
        out_y_o    <= rdc[1];
        out_z_o    <= nd3 ? rdc[2] : '0;
        out_last_o <= i_q == cnt_q - 1'b1;
        out_ovf_o  <= ovf_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    stat_o.last       = last_q;
    stat_o.sp_zero    = sp_q == '0;
    stat_o.seg_skip   = (NW'(e_q) <= NW'(s_q) + 1'b1) || (NW'(e_q) >= cnt_q);
    stat_o.dot_le0    = dot_q <= 0;
    stat_o.ssq_le_dot = $signed({2'b00, ssq_q}) <= dot_q;
    stat_o.have       = have_q;
    stat_o.q_gt       = cq_q > bq_q;
    stat_o.q_eq       = cq_q == bq_q;
    stat_o.x_gt       = x_q > mprod;
    stat_o.p_end      = NW'(p_q) + 1'b1 == NW'(e_q);
    stat_o.keep_best  = (CMPW'(bq_q) > CMPW'(tol2_q)) ||
                        ((CMPW'(bq_q) == CMPW'(tol2_q)) && (br_q != '0));
    stat_o.i_end      = i_q == cnt_q;
    stat_o.keep_i     = keep_q[i_q[IW-1:0]];
    stat_o.out_busy   = ovalid_q;
    stat_o.mul_busy   = mul_busy;
    stat_o.div_busy   = div_busy;
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= NW'(MAX_POINTS)) else $error("segment stack pointer out of range");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MAX_POINTS)) else $error("stored count out of range");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(op == pdps_pkg::OP_OUT)) else $error("result without load");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == pdps_pkg::OP_DIV) |-> !div_busy) else $error("divider restarted while busy");

endmodule

`default_nettype wire

[rtl/pdps_ctrl.sv]
// sequencer for loading, segment walk and result output
// depends on pdps_pkg; commands pdps_datapath
`default_nettype none

module pdps_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pdps_pkg::stat_t stat_i,
  output pdps_pkg::cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ, ST_DEC, ST_INIT, ST_POP, ST_SEG, ST_SEG_CHK, ST_RDE, ST_GETE,
    ST_SV, ST_SQSV, ST_SSQ, ST_RDP, ST_PV, ST_MDOT, ST_DOT, ST_PP, ST_BR,
    ST_QPP, ST_PVE, ST_MPP2, ST_QSUM, ST_MUL1, ST_W1, ST_NUM1, ST_MUL2, ST_W2,
    ST_NUM2, ST_DIV, ST_WD, ST_QDIV, ST_CMP, ST_MULX, ST_WX, ST_XSAVE, ST_MULY,
    ST_WY, ST_XCMP, ST_BEST, ST_NEXTP, ST_FIN, ST_KEEP, ST_PUSH2, ST_EMINIT,
    ST_EMCHK, ST_RDI, ST_OUT, ST_EMWAIT, ST_NEXTI, ST_CLEAR
  } state_e;

  state_e state_q, state_d;
  pdps_pkg::op_e op;

  always_comb begin
    state_d = state_q;
    op      = pdps_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        op      = pdps_pkg::OP_TAKE;
        state_d = ST_SQ;
      end
      ST_SQ: begin op = pdps_pkg::OP_SQREF; state_d = ST_DEC; end
      ST_DEC: begin
        op      = pdps_pkg::OP_STORE;
        state_d = stat_i.last ? ST_INIT : ST_IDLE;
      end
      ST_INIT: begin op = pdps_pkg::OP_INIT; state_d = ST_POP; end
      ST_POP: begin
        if (stat_i.sp_zero) state_d = ST_EMINIT;
        else begin
          op      = pdps_pkg::OP_POP;
          state_d = ST_SEG;
        end
      end
      ST_SEG:     begin op = pdps_pkg::OP_SEG; state_d = ST_SEG_CHK; end
      ST_SEG_CHK: state_d = stat_i.seg_skip ? ST_POP : ST_RDE;
      ST_RDE:     begin op = pdps_pkg::OP_RDE;  state_d = ST_GETE; end
      ST_GETE:    begin op = pdps_pkg::OP_GETE; state_d = ST_SV; end
      ST_SV:      begin op = pdps_pkg::OP_SV;   state_d = ST_SQSV; end
      ST_SQSV:    begin op = pdps_pkg::OP_SQSV; state_d = ST_SSQ; end
      ST_SSQ:     begin op = pdps_pkg::OP_SSQ;  state_d = ST_RDP; end
      ST_RDP:     begin op = pdps_pkg::OP_RDP;  state_d = ST_PV; end
      ST_PV:      begin op = pdps_pkg::OP_PV;   state_d = ST_MDOT; end
      ST_MDOT:    begin op = pdps_pkg::OP_MDOT; state_d = ST_DOT; end
      ST_DOT:     begin op = pdps_pkg::OP_DOT;  state_d = ST_PP; end
      ST_PP:      begin op = pdps_pkg::OP_PP;   state_d = ST_BR; end
      // closest point before the start, past the end, or on the segment
      ST_BR: begin
        if (stat_i.dot_le0)         state_d = ST_QPP;
        else if (stat_i.ssq_le_dot) state_d = ST_PVE;
        else                        state_d = ST_MUL1;
      end
      ST_QPP:  begin op = pdps_pkg::OP_QPP;  state_d = ST_CMP; end
      ST_PVE:  begin op = pdps_pkg::OP_PVE;  state_d = ST_MPP2; end
      ST_MPP2: begin op = pdps_pkg::OP_MPP2; state_d = ST_QSUM; end
      ST_QSUM: begin op = pdps_pkg::OP_QSUM; state_d = ST_CMP; end
      ST_MUL1: begin op = pdps_pkg::OP_MUL1; state_d = ST_W1; end
      ST_W1:   if (!stat_i.mul_busy) state_d = ST_NUM1;
      ST_NUM1: begin op = pdps_pkg::OP_NUM1; state_d = ST_MUL2; end
      ST_MUL2: begin op = pdps_pkg::OP_MUL2; state_d = ST_W2; end
      ST_W2:   if (!stat_i.mul_busy) state_d = ST_NUM2;
      ST_NUM2: begin op = pdps_pkg::OP_NUM2; state_d = ST_DIV; end
      ST_DIV:  begin op = pdps_pkg::OP_DIV;  state_d = ST_WD; end
      ST_WD:   if (!stat_i.div_busy) state_d = ST_QDIV;
      ST_QDIV: begin op = pdps_pkg::OP_QDIV; state_d = ST_CMP; end
      ST_CMP: begin
        if (!stat_i.have || stat_i.q_gt) state_d = ST_BEST;
        else if (stat_i.q_eq)            state_d = ST_MULX;
        else                             state_d = ST_NEXTP;
      end
      // equal quotients: compare remainders cross-multiplied
      ST_MULX:  begin op = pdps_pkg::OP_MULX; state_d = ST_WX; end
      ST_WX:    if (!stat_i.mul_busy) state_d = ST_XSAVE;
      ST_XSAVE: begin op = pdps_pkg::OP_XSAVE; state_d = ST_MULY; end
      ST_MULY:  begin op = pdps_pkg::OP_MULY; state_d = ST_WY; end
      ST_WY:    if (!stat_i.mul_busy) state_d = ST_XCMP;
      ST_XCMP:  state_d = stat_i.x_gt ? ST_BEST : ST_NEXTP;
      ST_BEST:  begin op = pdps_pkg::OP_BEST; state_d = ST_NEXTP; end
      ST_NEXTP: begin
        op      = pdps_pkg::OP_NEXTP;
        state_d = stat_i.p_end ? ST_FIN : ST_RDP;
      end
      ST_FIN:   state_d = stat_i.keep_best ? ST_KEEP : ST_POP;
      ST_KEEP:  begin op = pdps_pkg::OP_KEEP;  state_d = ST_PUSH2; end
      ST_PUSH2: begin op = pdps_pkg::OP_PUSH2; state_d = ST_POP; end
      ST_EMINIT: begin op = pdps_pkg::OP_EMINIT; state_d = ST_EMCHK; end
      ST_EMCHK: begin
        if (stat_i.i_end)       state_d = ST_CLEAR;
        else if (stat_i.keep_i) state_d = ST_RDI;
        else                    state_d = ST_NEXTI;
      end
      ST_RDI:    begin op = pdps_pkg::OP_RDI; state_d = ST_OUT; end
      ST_OUT:    begin op = pdps_pkg::OP_OUT; state_d = ST_EMWAIT; end
      ST_EMWAIT: if (!stat_i.out_busy) state_d = ST_NEXTI;
      ST_NEXTI:  begin op = pdps_pkg::OP_NEXTI; state_d = ST_EMCHK; end
      ST_CLEAR:  begin op = pdps_pkg::OP_CLEAR; state_d = ST_IDLE; end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign cmd_o.op   = op;

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == pdps_pkg::OP_TAKE) |=> (state_q == ST_SQ)) else $error("load out of order");

  a_clear_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> in_ready_o) else $error("no return to idle");

  a_wait_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEXTI) |-> !stat_i.out_busy || $past(state_q == ST_EMCHK))
    else $error("next point before request taken");

endmodule

`default_nettype wire

[rtl/polyline_douglas_peucker_simplify_top.sv]
// Douglas-Peucker polyline simplifier with radial prefilter: takes points in
// over a stream and, on the point marked last, emits the kept points in input
// order. Loading steps through take, square and store decision for each point.
// In the segment walk, for an interior point whose nearest point lies on the
// segment, the serial multiplier runs twice and the divider once, plus two more
// multiplier passes on a tie of quotients. Output of each kept point waits on
// m_axis_tready.
// depends on pdps_pkg, pdps_ctrl, pdps_datapath
`default_nettype none

module polyline_douglas_peucker_simplify_top #(
  parameter int MAX_POINTS  = pdps_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pdps_pkg::COORD_WIDTH_DEF,
  localparam int DATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [DATA_W-1:0]                   s_axis_tdata,  // coord_x, coord_y, coord_z
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [DATA_W-1:0]                        m_axis_tdata,  // out_x, out_y, out_z
  output logic                                     m_axis_tlast,
  output logic                                     m_axis_tuser,  // overflowed
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pdps_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [pdps_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pdps_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  localparam int CW = COORD_WIDTH;

  logic [pdps_pkg::TOL_W-1:0] tol_q;
  logic                       hq_q;
  logic [pdps_pkg::DIM_W-1:0] dims_q;
  logic                       wr;
  logic [1:0]                 ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= '0;
      hq_q   <= 1'b1;
      dims_q <= 2'd2;
    end else if (wr) begin
      unique case (ridx)
        pdps_pkg::CFG_TOL: tol_q  <= pwdata[pdps_pkg::TOL_W-1:0];
        pdps_pkg::CFG_HQ:  hq_q   <= pwdata[0];
        pdps_pkg::CFG_DIM: dims_q <= pwdata[pdps_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      pdps_pkg::CFG_TOL: prdata = pdps_pkg::CFG_DATA_W'(tol_q);
      pdps_pkg::CFG_HQ:  prdata = pdps_pkg::CFG_DATA_W'(hq_q);
      pdps_pkg::CFG_DIM: prdata = pdps_pkg::CFG_DATA_W'(dims_q);
      default:           prdata = '0;
    endcase
  end

  pdps_pkg::cmd_t  cmd;
  pdps_pkg::stat_t stat;
  logic signed [CW-1:0] ox, oy, oz;

  pdps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdps_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_x_i      (s_axis_tdata[CW-1:0]),
    .in_y_i      (s_axis_tdata[2*CW-1:CW]),
    .in_z_i      (s_axis_tdata[3*CW-1:2*CW]),
    .in_last_i   (s_axis_tlast),
    .tol_i       (tol_q),
    .hq_i        (hq_q),
    .dims_i      (dims_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_x_o     (ox),
    .out_y_o     (oy),
    .out_z_o     (oz),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  assign m_axis_tdata = DATA_W'({oz, oy, ox});

endmodule

`default_nettype wire

[verif/tb_top.sv]
// testbench for the polyline simplifier: drives point streams and register writes,
// predicts the kept points with its own scoreboard and compares every output request
// depends on pdps_pkg and polyline_douglas_peucker_simplify_top
`timescale 1ns / 1ps

module tb_top;

  localparam int NPTS = 64;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    bit          last;
    bit          ovf;
  } kept_pt_t;

  class pdps_scoreboard;
    bit [15:0]   tol;
    bit          hq;
    bit [1:0]    dims;
    longint      pts[NPTS][3];
    bit          keep[NPTS];
    int          cnt;
    longint      refp[3];
    bit          ovf;
    int          seg_s[NPTS];
    int          seg_e[NPTS];
    longint      sv[3];
    kept_pt_t    kept_q[$];
    int          errors;

    function new();
      tol = 0;
      hq = 1;
      dims = 2;
      cnt = 0;
      ovf = 0;
      errors = 0;
      for (int i = 0; i < NPTS; i++) keep[i] = 0;
      for (int k = 0; k < 3; k++) refp[k] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] val);
      if (idx == pdps_pkg::CFG_TOL) tol = val[15:0];
      else if (idx == pdps_pkg::CFG_HQ) hq = val[0];
      else if (idx == pdps_pkg::CFG_DIM) dims = val[1:0];
    endfunction

    function int ndims();
      return (dims == pdps_pkg::DIM_3D) ? 3 : 2;
    endfunction

    function longint unsigned sq_dist(int a, int b, int nd);
      longint unsigned s;
      longint d;
      s = 0;
      for (int k = 0; k < nd; k++) begin
        d = pts[a][k] - pts[b][k];
        s += longint'(d * d);
      end
      return s;
    endfunction

    // squared distance of p from segment (s,e) as quotient, remainder, divisor
    function void seg_dist(int p, int s, int e, int nd, longint unsigned ssq,
                           output longint unsigned q, output longint unsigned r,
                           output longint unsigned d);
      longint pv;
      longint dot;
      longint unsigned pp;
      bit [127:0] num;
      dot = 0;
      pp = 0;
      r = 0;
      d = 1;
      for (int k = 0; k < nd; k++) begin
        pv = pts[p][k] - pts[s][k];
        dot += pv * sv[k];
        pp += pv * pv;
      end
      if (dot <= 0) begin
        q = pp;
      end else if (ssq <= longint'(unsigned'(dot))) begin
        q = sq_dist(p, e, nd);
      end else begin
        num = 128'(pp) * 128'(ssq) - 128'(unsigned'(dot)) * 128'(unsigned'(dot));
        q = 64'(num / 128'(ssq));
        r = 64'(num % 128'(ssq));
        d = ssq;
      end
    endfunction

    function void simplify(int n);
      longint unsigned tol2;
      int nd;
      int sp;
      int s;
      int e;
      int best;
      longint unsigned ssq;
      longint unsigned bq, br, bd, q, r, d;
      bit have;
      bit gt;
      tol2 = longint'(tol) * longint'(tol);
      nd = ndims();
      keep[0] = 1;
      keep[n-1] = 1;
      seg_s[0] = 0;
      seg_e[0] = n - 1;
      sp = 1;
      while (sp > 0) begin
        sp--;
        s = seg_s[sp];
        e = seg_e[sp];
        if (e <= s + 1 || e >= n) continue;
        ssq = 0;
        for (int k = 0; k < 3; k++) sv[k] = 0;
        for (int k = 0; k < nd; k++) begin
          sv[k] = pts[e][k] - pts[s][k];
          ssq += sv[k] * sv[k];
        end
        best = s + 1;
        bq = 0; br = 0; bd = 1;
        have = 0;
        for (int p = s + 1; p < e; p++) begin
          seg_dist(p, s, e, nd, ssq, q, r, d);
          if (q != bq) gt = q > bq;
          else gt = (128'(r) * 128'(bd)) > (128'(br) * 128'(d));
          if (!have || gt) begin
            bq = q; br = r; bd = d;
            best = p;
            have = 1;
          end
        end
        if (bq > tol2 || (bq == tol2 && br != 0)) begin
          keep[best] = 1;
          if (sp < NPTS) begin
            seg_s[sp] = best; seg_e[sp] = e; sp++;
          end
          if (sp < NPTS) begin
            seg_s[sp] = s; seg_e[sp] = best; sp++;
          end
        end
      end
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit last);
      int nd;
      bit store;
      longint unsigned s2;
      longint dd;
      longint pt[3];
      kept_pt_t kp;
      nd = ndims();
      pt[0] = x; pt[1] = y; pt[2] = z;
      if (hq || cnt == 0 || last) begin
        store = 1;
      end else begin
        s2 = 0;
        for (int k = 0; k < nd; k++) begin
          dd = pt[k] - refp[k];
          s2 += dd * dd;
        end
        store = s2 > longint'(tol) * longint'(tol);
      end
      if (store) begin
        if (cnt < NPTS) begin
          for (int k = 0; k < 3; k++) begin
            pts[cnt][k] = pt[k];
            refp[k] = pt[k];
          end
          cnt++;
        end else begin
          ovf = 1;
        end
      end
      if (!last) return;
      if (cnt > 0) simplify(cnt);
      for (int i = 0; i < cnt; i++) begin
        if (!keep[i]) continue;
        kp.x = 16'(pts[i][0]);
        kp.y = 16'(pts[i][1]);
        kp.z = (nd == 3) ? 16'(pts[i][2]) : 16'd0;
        kp.last = (i == cnt - 1);
        kp.ovf = ovf;
        kept_q = {kept_q, kp};
      end
      for (int i = 0; i < NPTS; i++) keep[i] = 0;
      cnt = 0;
      ovf = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [47:0] data, logic last, logic user);
      kept_pt_t e;
      if (kept_q.size() == 0) begin
        report_mismatch($sformatf("unexpected point %h", data));
        return;
      end
      e = kept_q.pop_front();
      if (data[15:0] !== e.x) report_mismatch($sformatf("x %h exp %h", data[15:0], e.x));
      if (data[31:16] !== e.y) report_mismatch($sformatf("y %h exp %h", data[31:16], e.y));
      if (data[47:32] !== e.z) report_mismatch($sformatf("z %h exp %h", data[47:32], e.z));
      if (last !== e.last) report_mismatch($sformatf("last %b exp %b", last, e.last));
      if (user !== e.ovf) report_mismatch($sformatf("overflow %b exp %b", user, e.ovf));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [pdps_pkg::CFG_ADDR_W-1:0] paddr;
  logic [pdps_pkg::CFG_DATA_W-1:0] pwdata;
  logic [pdps_pkg::CFG_DATA_W-1:0] prdata;
  logic        pready;

  pdps_scoreboard simp_sb;
  bit          quiet;
  int          stall_left;
  int          items_sent;
  int          big_runs;

  polyline_douglas_peucker_simplify_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        simp_sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  task send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    simp_sb.note_point(x, y, z, last);
    items_sent++;
  endtask

  task write_reg(logic [1:0] idx, bit [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    simp_sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task wait_idle();
    s_axis_tvalid <= 1'b0;
    while (simp_sb.kept_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task set_mode(bit [15:0] tol, bit hq, bit [1:0] dims);
    wait_idle();
    write_reg(pdps_pkg::CFG_TOL, tol);
    write_reg(pdps_pkg::CFG_HQ, hq);
    write_reg(pdps_pkg::CFG_DIM, dims);
  endtask

  // random polyline: a walk of small steps, or full-range scatter
  task send_polyline(int n, bit scatter, int step);
    logic signed [15:0] c[3];
    int v;
    for (int k = 0; k < 3; k++) c[k] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (scatter) begin
          c[k] = 16'($urandom);
        end else begin
          v = int'(c[k]) + int'($urandom_range(0, 2 * step)) - step;
          c[k] = (v > 32767) ? 16'sd32767 : (v < -32768) ? -16'sd32768 : 16'(v);
        end
      end
      send_point(c[0], c[1], c[2], i == n - 1);
    end
  endtask

  initial begin
    simp_sb = new();
    quiet = 0;
    items_sent = 0;
    big_runs = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point, then a two point line across the full range
    send_point(16'h1234, 16'h8000, 16'h7fff, 1);
    send_point(16'h8000, 16'h8000, 16'h8000, 0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1);
    // 3d, zero tolerance: both middle points lie off the line and are kept
    set_mode(16'd0, 1'b1, 2'd3);
    send_point(16'h8000, 16'h8000, 16'h8000, 0);
    send_point(16'h0000, 16'h0000, 16'h0000, 0);
    send_point(16'h7fff, 16'h7fff, 16'hffff, 0);
    send_point(16'h7fff, 16'h8000, 16'h7fff, 1);
    // tie between two points and points projecting before start and past end
    set_mode(16'd1, 1'b1, 2'd2);
    send_point(16'd0, 16'd0, 16'd0, 0);
    send_point(16'hfffb, 16'd3, 16'h5555, 0);
    send_point(16'd5, 16'd3, 16'haaaa, 0);
    send_point(16'd15, 16'hfffd, 16'd0, 0);
    send_point(16'd10, 16'd0, 16'd0, 1);
    // prefilter: close points skipped, last stored anyway, max tolerance
    set_mode(16'd10, 1'b0, 2'd3);
    send_point(16'd0, 16'd0, 16'd0, 0);
    send_point(16'd3, 16'd4, 16'd5, 0);
    send_point(16'd30, 16'd4, 16'd0, 0);
    send_point(16'd31, 16'd5, 16'd1, 1);
    set_mode(16'hffff, 1'b0, 2'd0);
    send_point(16'h8000, 16'h7fff, 16'd0, 0);
    send_point(16'h7fff, 16'h8000, 16'd9, 0);
    send_point(16'h0, 16'h0, 16'd9, 1);

    while (items_sent < 290) begin
      case ($urandom_range(0, 4))
        0: set_mode(16'd0, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        1: set_mode(16'hffff, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        default: set_mode(16'($urandom_range(0, 300)), 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        if (big_runs < 3 && $urandom_range(0, 15) == 0) begin
          // at or past capacity: points beyond capacity, even the marked last, are dropped
          big_runs++;
          send_polyline(int'($urandom_range(64, 67)), 1'($urandom_range(0, 1)), 200);
        end else begin
          send_polyline(int'($urandom_range(2, 12)), $urandom_range(0, 3) == 0,
                        int'($urandom_range(1, 400)));
        end
      end
    end

    wait_idle();
    if (simp_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/pdps_pkg.sv
rtl/pdps_mul.sv
rtl/pdps_div.sv
rtl/pdps_datapath.sv
rtl/pdps_ctrl.sv
rtl/polyline_douglas_peucker_simplify_top.sv
verif/tb_top.sv
